/* design/csah_pkg.sv */
package csah_pkg;

  // field widths
  localparam int unsigned CHAN_W  = 7;
  localparam int unsigned BKT_W   = 5;
  localparam int unsigned COUNT_W = 8;

  // histogram shape
  localparam int unsigned NUM_BUCKETS  = 32;
  localparam int unsigned BUCKET_LIMIT = 255;

  // divider: dividend is offset * NUM_BUCKETS, divisor is the span (up to 2**CHAN_W)
  localparam int unsigned PROD_W = CHAN_W + $clog2(NUM_BUCKETS + 1);
  localparam int unsigned REM_W  = CHAN_W + 1;
  localparam int unsigned STEP_W = $clog2(PROD_W);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = CHAN_W;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CHANNEL  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DWELL = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NOP   = 2'd3
  } csah_cmd_e;

  typedef struct packed {
    csah_cmd_e command;
    logic      carrier_detected;
  } csah_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  tune_channel;
    logic [BKT_W-1:0]   bucket_index;
    logic [COUNT_W-1:0] bucket_count;
    logic               bucket_incremented;
    logic               sweep_wrapped;
    logic               scanner_active;
  } csah_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic update;
    logic load_out;
  } csah_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_free;
  } csah_sts_t;

endpackage

/* design/csah_ctrl.sv */
module csah_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csah_pkg::csah_sts_t sts_i,
  output csah_pkg::csah_ctl_t ctl_o
);
  import csah_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    ctl_o          = '0;
    ctl_o.accept   = in_valid_i && (state_q == ST_IDLE);
    ctl_o.div_step = (state_q == ST_DIV);
    ctl_o.update   = (state_q == ST_UPD);
    ctl_o.load_out = (state_q == ST_OUT) && sts_i.out_free;
    in_stall_o     = (state_q != ST_IDLE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.needs_div ? ST_DIV : ST_UPD;
        end
      end
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: state_d = ST_OUT;
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/csah_dp.sv */
module csah_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [csah_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [csah_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  csah_pkg::csah_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output csah_pkg::csah_out_t                 out_data_o,
  input  csah_pkg::csah_ctl_t                 ctl_i,
  output csah_pkg::csah_sts_t                 sts_o
);
  import csah_pkg::*;

  // configuration and scan state
  logic [CHAN_W-1:0]  first_q, last_q;
  logic [CHAN_W-1:0]  chan_q, chan_d;
  logic               running_q, running_d;
  logic [COUNT_W-1:0] buckets_q [NUM_BUCKETS];

  // latched item
  csah_cmd_e cmd_q;
  logic      det_q;

  // divider
  logic [PROD_W-1:0] num_q;
  logic [REM_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;

  // result staging and output register
  csah_out_t res_q, res_d;
  csah_out_t out_q;
  logic      out_valid_q;

  logic [CHAN_W-1:0]  last_eff, offset;
  logic [REM_W-1:0]   span, rem_sh, rem_d;
  logic               ge;
  logic [PROD_W-1:0]  prod;
  logic [BKT_W-1:0]   bkt;
  logic [COUNT_W-1:0] cur_cnt, new_cnt;
  logic               can_inc, clear_all, bump;

  // last below first counts as equal to first
  assign last_eff = (last_q < first_q) ? first_q : last_q;
  // channel below first (first raised mid-scan) maps to offset zero
  assign offset   = (chan_q >= first_q) ? (chan_q - first_q) : '0;
  assign span     = REM_W'(last_eff) - REM_W'(first_q) + REM_W'(1);
  assign prod     = PROD_W'(offset) * PROD_W'(NUM_BUCKETS);

  // restoring divide, one quotient bit per step
  assign rem_sh = {rem_q[REM_W-2:0], num_q[PROD_W-1]};
  assign ge     = (rem_sh >= span);
  assign rem_d  = ge ? (rem_sh - span) : rem_sh;

  // clamp to last bucket
  assign bkt     = (num_q > PROD_W'(NUM_BUCKETS - 1)) ? BKT_W'(NUM_BUCKETS - 1)
                                                      : num_q[BKT_W-1:0];
  assign cur_cnt = buckets_q[bkt];
  assign can_inc = (cur_cnt < COUNT_W'(BUCKET_LIMIT));
  assign new_cnt = can_inc ? (cur_cnt + COUNT_W'(1)) : cur_cnt;

  always_comb begin
    chan_d                  = chan_q;
    running_d               = running_q;
    clear_all               = 1'b0;
    bump                    = 1'b0;
    res_d                   = '0;
    unique case (cmd_q)
      CMD_START: begin
        clear_all = 1'b1;
        running_d = 1'b1;
        chan_d    = first_q;
      end
      CMD_DWELL: begin
        if (running_q) begin
          if (det_q) begin
            bump                     = can_inc;
            res_d.bucket_index       = bkt;
            res_d.bucket_count       = new_cnt;
            res_d.bucket_incremented = can_inc;
          end
          if (chan_q >= last_eff) begin
            chan_d              = first_q;
            res_d.sweep_wrapped = 1'b1;
          end else begin
            chan_d = chan_q + CHAN_W'(1);
          end
        end
      end
      CMD_STOP: running_d = 1'b0;
      CMD_NOP: ;
      default: ;
    endcase
    res_d.tune_channel   = chan_d;
    res_d.scanner_active = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      last_q      <= CHAN_W'(125);
      chan_q      <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        buckets_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FIRST_CHANNEL: first_q <= cfg_data_i;
          REG_LAST_CHANNEL:  last_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl_i.update) begin
        chan_q    <= chan_d;
        running_q <= running_d;
        if (clear_all) begin
          for (int i = 0; i < NUM_BUCKETS; i++) begin
            buckets_q[i] <= '0;
          end
        end else if (bump) begin
          buckets_q[bkt] <= new_cnt;
        end
      end
      if (ctl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q  <= in_data_i.command;
      det_q  <= in_data_i.carrier_detected;
      num_q  <= prod;
      rem_q  <= '0;
      step_q <= '0;
    end else if (ctl_i.div_step) begin
      num_q  <= {num_q[PROD_W-2:0], ge};
      rem_q  <= rem_d;
      step_q <= step_q + STEP_W'(1);
    end
    if (ctl_i.update) begin
      res_q <= res_d;
    end
    if (ctl_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign sts_o.needs_div = (in_data_i.command == CMD_DWELL) && in_data_i.carrier_detected
                           && running_q;
  assign sts_o.div_last  = (step_q == STEP_W'(PROD_W - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/channel_sweep_activity_histogram.sv */
// radio channel sweep with a carrier-activity histogram. a start command clears all
// buckets, starts the scan and tunes to the first channel; a dwell while scanning steps
// to the next channel (wrapping after the last one, flagged in sweep_wrapped) and, on a
// carrier detection, raises bucket (channel-first)*NUM_BUCKETS/(last-first+1), clamped to
// the last bucket and saturating at BUCKET_LIMIT; stop ends the scan. a last channel below
// the first acts as equal to the first. every input transfer gives exactly one output
// transfer. one item at a time: a detected dwell while scanning passes through the
// one-bit-per-cycle restoring divider that maps the channel to its bucket before its
// update, every other item goes straight to the update. the input stays stalled until the
// result moves into the output register, which waits while that register is still full;
// the next input transfer is taken even while the previous result still waits in the output
// register.
// configuration writes are meant for idle periods only.
module channel_sweep_activity_histogram (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [csah_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [csah_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // command / dwell result channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  csah_pkg::csah_in_t              in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output csah_pkg::csah_out_t             out_data_o
);
  import csah_pkg::*;

  csah_ctl_t ctl;
  csah_sts_t sts;

  // sequencer: idle, divide, update, hand off to output register
  csah_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // channel state, buckets, divider and output register
  csah_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

  // an input transfer always closes the input side for the next cycle
  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item was in flight");

  // a result is never written over one that is still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> sts.out_free)
    else $error("output register overwritten");

  // a raised bucket holds a nonzero count and the scan is running
  a_inc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bucket_incremented)
      |-> (out_data_o.bucket_count != '0) && out_data_o.scanner_active)
    else $error("bucket raised with zero count or while stopped");

endmodule

/* tb/sv/sweep_histogram_checker.sv */
module sweep_histogram_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csah_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [csah_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  csah_pkg::csah_in_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  csah_pkg::csah_out_t             out_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csah_pkg::*;

  // keep the log short when the block is badly off
  localparam int unsigned MAX_LINES = 200;

  // shadow of the sweep state and its two registers
  logic [CHAN_W-1:0]  first_ch;
  logic [CHAN_W-1:0]  last_ch;
  logic [CHAN_W-1:0]  cur_ch;
  logic [COUNT_W-1:0] hist [NUM_BUCKETS];
  logic               running;

  csah_out_t   predicted_reports [$];
  csah_out_t   oldest;
  int unsigned fail_count;
  int unsigned pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_count < MAX_LINES) begin
      $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  // one command or dwell result through the sweep, returns the status it reports
  function automatic csah_out_t sweep_step(csah_in_t item);
    csah_out_t         res;
    logic [CHAN_W-1:0] last_eff;
    int unsigned       offset;
    int unsigned       span;
    int unsigned       bkt;
    res = '0;
    // a last channel below the first acts as the first
    last_eff = (last_ch < first_ch) ? first_ch : last_ch;
    case (item.command)
      CMD_START: begin
        foreach (hist[i]) hist[i] = '0;
        running = 1'b1;
        cur_ch  = first_ch;
      end
      CMD_DWELL: begin
        if (running) begin
          if (item.carrier_detected) begin
            // channel below first after a mid-scan change counts as offset zero
            offset = (cur_ch >= first_ch) ? int'(cur_ch) - int'(first_ch) : 0;
            span   = int'(last_eff) - int'(first_ch) + 1;
            bkt    = offset * NUM_BUCKETS / span;
            if (bkt > NUM_BUCKETS - 1) bkt = NUM_BUCKETS - 1;
            if (hist[bkt] < BUCKET_LIMIT) begin
              hist[bkt]++;
              res.bucket_incremented = 1'b1;
            end
            res.bucket_index = bkt[BKT_W-1:0];
            res.bucket_count = hist[bkt];
          end
          if (cur_ch >= last_eff) begin
            cur_ch = first_ch;
            res.sweep_wrapped = 1'b1;
          end else begin
            cur_ch = cur_ch + 1'b1;
          end
        end
      end
      CMD_STOP: running = 1'b0;
      default: ;
    endcase
    res.tune_channel   = cur_ch;
    res.scanner_active = running;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_ch   = '0;
      last_ch    = CHAN_W'(125);
      cur_ch     = '0;
      foreach (hist[i]) hist[i] = '0;
      running    = 1'b0;
      fail_count = 0;
      predicted_reports.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FIRST_CHANNEL: first_ch = cfg_data_i;
          REG_LAST_CHANNEL:  last_ch  = cfg_data_i;
          default: ;
        endcase
      end
      // a result leaving now belongs to an earlier transfer, so check it first
      if (out_valid_i && !out_stall_i) begin
        if (predicted_reports.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_data_i), 0);
        end else begin
          oldest = predicted_reports.pop_front();
          if (out_data_i.tune_channel !== oldest.tune_channel)
            report_mismatch("tune_channel", 32'(out_data_i.tune_channel),
                            32'(oldest.tune_channel));
          if (out_data_i.bucket_index !== oldest.bucket_index)
            report_mismatch("bucket_index", 32'(out_data_i.bucket_index),
                            32'(oldest.bucket_index));
          if (out_data_i.bucket_count !== oldest.bucket_count)
            report_mismatch("bucket_count", 32'(out_data_i.bucket_count),
                            32'(oldest.bucket_count));
          if (out_data_i.bucket_incremented !== oldest.bucket_incremented)
            report_mismatch("bucket_incremented", 32'(out_data_i.bucket_incremented),
                            32'(oldest.bucket_incremented));
          if (out_data_i.sweep_wrapped !== oldest.sweep_wrapped)
            report_mismatch("sweep_wrapped", 32'(out_data_i.sweep_wrapped),
                            32'(oldest.sweep_wrapped));
          if (out_data_i.scanner_active !== oldest.scanner_active)
            report_mismatch("scanner_active", 32'(out_data_i.scanner_active),
                            32'(oldest.scanner_active));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_reports.push_back(sweep_step(in_data_i));
      end
    end
    pending = predicted_reports.size();
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csah_pkg::*;

  // no transfer for this many cycles means the block hung
  localparam int unsigned QUIET_LIMIT = 4000;
  // worst item is a detected dwell, which goes through the divider; leave room on top
  localparam int unsigned SETTLE_CYCLES = 24;
  // long receiver hold-off so the block backs up into its input
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned TOTAL_ITEMS = 1100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  csah_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  csah_out_t             out_data_o;

  int unsigned fail_count;
  int unsigned pending;

  // idling mix, percent of cycles each side sits out
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;
  logic        hold_req;

  channel_sweep_activity_histogram i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  sweep_histogram_checker u_sweep_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stall, plus one long hold-off counted here
  initial begin
    int unsigned hold_left = 0;
    bit          hold_taken = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin
    int unsigned quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // one transfer on the command channel, with random gaps ahead of it
  task automatic send_item(csah_cmd_e cmd, logic det);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= csah_in_t'{command: cmd, carrier_detected: det};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    // idling phases: sender light and receiver heavy, then swapped, then none
    if (items_sent < TOTAL_ITEMS / 3) begin
      send_idle_pct = 8;
      recv_idle_pct = 62;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 62;
      recv_idle_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    // with nobody idling, hold the receiver off once and keep offering items
    if (items_sent == 800) hold_req <= 1'b1;
  endtask

  // registers change only with nothing in flight
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_sweep(int unsigned first, int unsigned last);
    wait_idle();
    write_reg(REG_FIRST_CHANNEL, CFG_DATA_W'(first));
    write_reg(REG_LAST_CHANNEL, CFG_DATA_W'(last));
  endtask

  initial begin
    int unsigned first;
    int unsigned last;
    int unsigned len;
    int unsigned pick;
    bit          saturated = 1'b0;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    hold_req      <= 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 62;
    items_sent    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset sweep 0..125, dwells and nop while stopped, stop while stopped
    send_item(CMD_DWELL, 1'b1);
    send_item(CMD_DWELL, 1'b0);
    send_item(CMD_NOP, 1'b1);
    send_item(CMD_STOP, 1'b0);
    send_item(CMD_START, 1'b1);
    send_item(CMD_DWELL, 1'b1);
    send_item(CMD_DWELL, 1'b0);
    send_item(CMD_NOP, 1'b0);
    send_item(CMD_STOP, 1'b1);
    send_item(CMD_DWELL, 1'b1);

    // short sweep with a wrap, then a restart while running
    set_sweep(5, 8);
    send_item(CMD_START, 1'b0);
    repeat (5) send_item(CMD_DWELL, 1'b1);
    send_item(CMD_START, 1'b0);
    send_item(CMD_DWELL, 1'b1);

    // last below first collapses to a one-channel sweep
    set_sweep(9, 3);
    send_item(CMD_START, 1'b0);
    send_item(CMD_DWELL, 1'b1);
    send_item(CMD_DWELL, 1'b1);

    // first raised mid-scan past the current channel
    set_sweep(2, 10);
    send_item(CMD_START, 1'b0);
    send_item(CMD_DWELL, 1'b0);
    send_item(CMD_DWELL, 1'b0);
    set_sweep(8, 10);
    send_item(CMD_DWELL, 1'b1);

    // random episodes: new sweep limits, mostly a start, then a burst of dwells
    while (items_sent < TOTAL_ITEMS) begin
      if (!saturated && items_sent > 500) begin
        // one-channel sweep piles every detection into bucket zero until it saturates
        saturated = 1'b1;
        first = $urandom_range(125);
        set_sweep(first, first);
        send_item(CMD_START, 1'b0);
        repeat (270) send_item(CMD_DWELL, 1'b1);
        continue;
      end
      pick = $urandom_range(9);
      case (pick)
        0: begin first = 0;   last = 125; end
        1: begin first = 125; last = 125; end
        2: begin first = 0;   last = 0;   end
        3: begin first = 125; last = 0;   end
        4: begin first = $urandom_range(125); last = first; end
        5: begin first = $urandom_range(125); last = $urandom_range(125); end
        default: begin
          // mostly short spans so sweeps wrap often
          first = $urandom_range(110);
          last  = first + $urandom_range(15);
        end
      endcase
      set_sweep(first, last);
      // without a start the old scan carries on under the new limits
      if ($urandom_range(3) != 0) send_item(CMD_START, 1'($urandom_range(1)));
      len = $urandom_range(60, 10);
      repeat (len) begin
        pick = $urandom_range(99);
        if (pick < 86)      send_item(CMD_DWELL, 1'($urandom_range(1)));
        else if (pick < 90) send_item(CMD_START, 1'($urandom_range(1)));
        else if (pick < 95) send_item(CMD_STOP, 1'($urandom_range(1)));
        else                send_item(CMD_NOP, 1'($urandom_range(1)));
      end
    end

    // drain and let the block settle before the verdict
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
